FILE: hdl/rmxt_pkg.sv
// ----------------------------------------------------------------------------
// rmxt_pkg: shared constants for the range max-xor trie
// Command and status codes and default sizes used by every file of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmxt_pkg;

   localparam int DEF_MAX_ENTRIES = 4096;
   localparam int DEF_KEY_BITS    = 24;

   localparam int STATUS_W = 2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/rmxt_front.sv
// ----------------------------------------------------------------------------
// rmxt_front: command intake and classification
// Owns the entry count and running xor, checks each command for errors and
// turns it into a job with its search key and the two version roots.
// ----------------------------------------------------------------------------
`default_nettype none

module rmxt_front #(
   parameter int MAX_ENTRIES = rmxt_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = rmxt_pkg::DEF_KEY_BITS,
   parameter int ENTRY_W     = $clog2(MAX_ENTRIES + 1),
   parameter int NODE_W      = $clog2(MAX_ENTRIES * (KEY_BITS + 1) + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_cmd,
   input  wire  [KEY_BITS-1:0]               req_value,
   input  wire  [ENTRY_W-1:0]                req_range_first,
   input  wire  [ENTRY_W-1:0]                req_range_last,
   output logic                              job_valid,
   input  wire                               job_stall,
   output logic                              job_query,
   output logic [rmxt_pkg::STATUS_W-1:0]     job_status,
   output logic [KEY_BITS-1:0]               job_key,
   output logic [NODE_W-1:0]                 job_root_a,
   output logic [NODE_W-1:0]                 job_root_b
);
   import rmxt_pkg::*;

   // every version adds one node per key bit plus a leaf
   localparam logic [NODE_W-1:0]  PATH_NODES = NODE_W'(KEY_BITS + 1);
   localparam logic [ENTRY_W-1:0] ENTRY_MAX  = ENTRY_W'(MAX_ENTRIES);

   logic [ENTRY_W-1:0]  count_ff, count_in;
   logic [KEY_BITS-1:0] xor_ff, xor_in;
   logic [NODE_W-1:0]   next_root_ff, next_root_in;
   logic                accepted;
   logic                full;
   logic                bad_range;

   // root of version k; version 0 is the empty trie
   function automatic logic [NODE_W-1:0] root_of(input logic [ENTRY_W-1:0] k);
      logic [NODE_W-1:0] base;
      base = NODE_W'(k) - NODE_W'(1);
      if (k == '0) begin
         return '0;
      end
      return base * PATH_NODES + NODE_W'(1);
   endfunction

   assign job_valid = req_valid;
   assign req_stall = job_stall;
   assign accepted  = req_valid && !job_stall;

   assign full      = count_ff >= ENTRY_MAX;
   assign bad_range = (req_range_first == '0) || (req_range_first > req_range_last) ||
                      (req_range_last > count_ff);

   always_comb begin
      job_query  = (req_cmd == CMD_QUERY);
      job_key    = xor_ff ^ req_value;
      if (req_cmd == CMD_APPEND) begin
         job_status = full ? STATUS_FULL : STATUS_OK;
         job_root_a = next_root_ff - PATH_NODES;
         job_root_b = next_root_ff;
      end else begin
         job_status = bad_range ? STATUS_RANGE : STATUS_OK;
         job_root_a = root_of(req_range_first - ENTRY_W'(1));
         job_root_b = root_of(req_range_last);
      end
   end

   always_comb begin
      count_in     = count_ff;
      xor_in       = xor_ff;
      next_root_in = next_root_ff;
      if (accepted && req_cmd == CMD_APPEND && !full) begin
         count_in     = count_ff + ENTRY_W'(1);
         xor_in       = job_key;
         next_root_in = next_root_ff + PATH_NODES;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ENTRY_W'(1);
         xor_ff       <= '0;
         next_root_ff <= PATH_NODES + NODE_W'(1);
      end else begin
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         next_root_ff <= next_root_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/rmxt_queue.sv
// ----------------------------------------------------------------------------
// rmxt_queue: two-entry job queue
// Decouples command intake from the trie engine so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module rmxt_queue #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_stall,
   input  wire  [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  wire              out_stall,
   output logic [WIDTH-1:0] out_data
);
   import rmxt_pkg::*;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/rmxt_back.sv
// ----------------------------------------------------------------------------
// rmxt_back: trie engine
// Holds the node store and walks it one level at a time: appends copy the
// previous version's path with tallies raised, queries steer by tally
// differences between two versions. Drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmxt_back #(
   parameter int MAX_ENTRIES = rmxt_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = rmxt_pkg::DEF_KEY_BITS,
   parameter int ENTRY_W     = $clog2(MAX_ENTRIES + 1),
   parameter int NODE_W      = $clog2(MAX_ENTRIES * (KEY_BITS + 1) + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               job_valid,
   output logic                              job_stall,
   input  wire                               job_query,
   input  wire  [rmxt_pkg::STATUS_W-1:0]     job_status,
   input  wire  [KEY_BITS-1:0]               job_key,
   input  wire  [NODE_W-1:0]                 job_root_a,
   input  wire  [NODE_W-1:0]                 job_root_b,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [rmxt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]               rsp_max_xor
);
   import rmxt_pkg::*;

   localparam int NODE_SLOTS = MAX_ENTRIES * (KEY_BITS + 1) + 1;
   localparam int WORD_W     = 2 * NODE_W + ENTRY_W;
   localparam int LVL_W      = $clog2(KEY_BITS + 1);
   // nodes 1 .. PATH_LAST hold the zero entry present after reset
   localparam logic [NODE_W-1:0] PATH_LAST = NODE_W'(KEY_BITS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_A_RD   = 3'd1;
   localparam logic [2:0] S_A_WR   = 3'd2;
   localparam logic [2:0] S_Q_NODE = 3'd3;
   localparam logic [2:0] S_Q_KIDS = 3'd4;
   localparam logic [2:0] S_Q_CMP  = 3'd5;

   logic [WORD_W-1:0]   node_mem [NODE_SLOTS];
   logic [WORD_W-1:0]   mem_a_ff, mem_b_ff;
   logic [WORD_W-1:0]   init_a_ff, init_b_ff;
   logic                fixed_a_ff, fixed_b_ff;
   logic [WORD_W-1:0]   word_a, word_b;
   logic [NODE_W-1:0]   addr_a, addr_b;
   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_word;

   logic [2:0]          state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_W-1:0]   node_a_ff, node_a_in;
   logic [NODE_W-1:0]   node_b_ff, node_b_in;
   logic [NODE_W-1:0]   alt_a_ff, alt_a_in;
   logic [NODE_W-1:0]   alt_b_ff, alt_b_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0] rsp_max_xor_ff, rsp_max_xor_in;
   logic                load_rsp;
   logic                out_free;
   logic                take;

   logic                side;
   logic                taken;
   logic [NODE_W-1:0]   fresh;
   logic [ENTRY_W-1:0]  tally_up;

   function automatic logic [NODE_W-1:0] child0(input logic [WORD_W-1:0] w);
      return w[WORD_W-1 -: NODE_W];
   endfunction

   function automatic logic [NODE_W-1:0] child1(input logic [WORD_W-1:0] w);
      return w[ENTRY_W +: NODE_W];
   endfunction

   function automatic logic [ENTRY_W-1:0] tally(input logic [WORD_W-1:0] w);
      return w[ENTRY_W-1:0];
   endfunction

   // null node and the initial zero path never live in the store
   function automatic logic [WORD_W-1:0] init_word(input logic [NODE_W-1:0] id);
      logic [WORD_W-1:0] w;
      w = '0;
      if (id != '0 && id < PATH_LAST) begin
         w = {id + NODE_W'(1), {NODE_W{1'b0}}, ENTRY_W'(1)};
      end else if (id == PATH_LAST) begin
         w = {{(2 * NODE_W){1'b0}}, ENTRY_W'(1)};
      end
      return w;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_word;
      end
      mem_a_ff <= node_mem[addr_a];
      mem_b_ff <= node_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      fixed_a_ff <= (addr_a <= PATH_LAST);
      fixed_b_ff <= (addr_b <= PATH_LAST);
      init_a_ff  <= init_word(addr_a);
      init_b_ff  <= init_word(addr_b);
   end

   assign word_a = fixed_a_ff ? init_a_ff : mem_a_ff;
   assign word_b = fixed_b_ff ? init_b_ff : mem_b_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign job_stall = !(state_ff == S_IDLE && out_free);
   assign take      = job_valid && !job_stall;

   assign side     = key_ff[KEY_BITS-1];
   assign fresh    = node_b_ff + NODE_W'(1);
   assign tally_up = tally(word_a) + ENTRY_W'(1);
   assign taken    = tally(word_a) != tally(word_b);

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      acc_in         = acc_ff;
      lvl_in         = lvl_ff;
      node_a_in      = node_a_ff;
      node_b_in      = node_b_ff;
      alt_a_in       = alt_a_ff;
      alt_b_in       = alt_b_ff;
      addr_a         = node_a_ff;
      addr_b         = node_b_ff;
      wr_en          = 1'b0;
      wr_addr        = node_b_ff;
      wr_word        = '0;
      load_rsp       = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_max_xor_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (job_status != STATUS_OK) begin
                  load_rsp      = 1'b1;
                  rsp_status_in = job_status;
               end else begin
                  key_in    = job_key;
                  acc_in    = '0;
                  lvl_in    = LVL_W'(KEY_BITS);
                  node_a_in = job_root_a;
                  node_b_in = job_root_b;
                  state_in  = job_query ? S_Q_NODE : S_A_RD;
               end
            end
         end
         S_A_RD: begin
            state_in = S_A_WR;
         end
         S_A_WR: begin
            // copy the previous node, bump its tally, point down the key side
            wr_en = 1'b1;
            if (lvl_ff == '0) begin
               wr_word  = {{(2 * NODE_W){1'b0}}, tally_up};
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               wr_word   = side ? {child0(word_a), fresh, tally_up}
                                : {fresh, child1(word_a), tally_up};
               node_a_in = side ? child1(word_a) : child0(word_a);
               node_b_in = fresh;
               key_in    = key_ff << 1;
               lvl_in    = lvl_ff - LVL_W'(1);
               state_in  = S_A_RD;
            end
         end
         S_Q_NODE: begin
            state_in = S_Q_KIDS;
         end
         S_Q_KIDS: begin
            // prefer the branch opposite the key bit
            node_a_in = side ? child0(word_a) : child1(word_a);
            node_b_in = side ? child0(word_b) : child1(word_b);
            alt_a_in  = side ? child1(word_a) : child0(word_a);
            alt_b_in  = side ? child1(word_b) : child0(word_b);
            addr_a    = node_a_in;
            addr_b    = node_b_in;
            state_in  = S_Q_CMP;
         end
         S_Q_CMP: begin
            acc_in = (acc_ff << 1) | KEY_BITS'(taken);
            if (!taken) begin
               node_a_in = alt_a_ff;
               node_b_in = alt_b_ff;
            end
            addr_a = node_a_in;
            addr_b = node_b_in;
            key_in = key_ff << 1;
            lvl_in = lvl_ff - LVL_W'(1);
            if (lvl_ff == LVL_W'(1)) begin
               load_rsp       = 1'b1;
               rsp_max_xor_in = acc_in;
               state_in       = S_IDLE;
            end else begin
               state_in = S_Q_KIDS;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      acc_ff    <= acc_in;
      lvl_ff    <= lvl_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      alt_a_ff  <= alt_a_in;
      alt_b_ff  <= alt_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_max_xor_ff <= rsp_max_xor_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_max_xor = rsp_max_xor_ff;

endmodule

`default_nettype wire

FILE: hdl/range_max_xor_persistent_trie.sv
// ----------------------------------------------------------------------------
// range_max_xor_persistent_trie: range maximum-xor over a prefix-xor history
//
// Request channel (req_*): cmd 0 appends value, cmd 1 queries entries
// range_first..range_last (1-based) with operand value. Transactions complete
// on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): one transaction per request, in order, carrying
// status (ok, bad range, store full) and max_xor (zero for appends/errors).
// Engine walk: an append visits each key bit level and the leaf, a query
// each key bit level, each level being a node store read followed by a write
// or a tally compare; errors skip the walk. Jobs pass through the job queue
// and the result register. Throughput is one request per engine walk, set by
// the single node store: the engine takes no new job until its walk is done.
// A two-entry job queue keeps intake open while the engine walks, and the
// result register holds while rsp_stall is high; the engine waits for it.
// Reset is immediate: the history holds the zero entry and no clearing pass
// runs, since the initial path is decoded from its node numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_xor_persistent_trie #(
   parameter int MAX_ENTRIES = rmxt_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = rmxt_pkg::DEF_KEY_BITS,
   parameter int ENTRY_W     = $clog2(MAX_ENTRIES + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_cmd,
   input  wire  [KEY_BITS-1:0]               req_value,
   input  wire  [ENTRY_W-1:0]                req_range_first,
   input  wire  [ENTRY_W-1:0]                req_range_last,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [rmxt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [KEY_BITS-1:0]               rsp_max_xor
);
   import rmxt_pkg::*;

   localparam int NODE_W = $clog2(MAX_ENTRIES * (KEY_BITS + 1) + 1);
   localparam int JOB_W  = 1 + STATUS_W + KEY_BITS + 2 * NODE_W;

   logic                f_valid, f_stall;
   logic                f_query;
   logic [STATUS_W-1:0] f_status;
   logic [KEY_BITS-1:0] f_key;
   logic [NODE_W-1:0]   f_root_a, f_root_b;

   logic                b_valid, b_stall;
   logic                b_query;
   logic [STATUS_W-1:0] b_status;
   logic [KEY_BITS-1:0] b_key;
   logic [NODE_W-1:0]   b_root_a, b_root_b;

   logic [JOB_W-1:0]    q_in, q_out;

   rmxt_front #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .ENTRY_W     (ENTRY_W),
      .NODE_W      (NODE_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .job_valid       (f_valid),
      .job_stall       (f_stall),
      .job_query       (f_query),
      .job_status      (f_status),
      .job_key         (f_key),
      .job_root_a      (f_root_a),
      .job_root_b      (f_root_b)
   );

   assign q_in = {f_query, f_status, f_key, f_root_a, f_root_b};

   rmxt_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_stall  (f_stall),
      .in_data   (q_in),
      .out_valid (b_valid),
      .out_stall (b_stall),
      .out_data  (q_out)
   );

   assign {b_query, b_status, b_key, b_root_a, b_root_b} = q_out;

   rmxt_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BITS    (KEY_BITS),
      .ENTRY_W     (ENTRY_W),
      .NODE_W      (NODE_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (b_valid),
      .job_stall   (b_stall),
      .job_query   (b_query),
      .job_status  (b_status),
      .job_key     (b_key),
      .job_root_a  (b_root_a),
      .job_root_b  (b_root_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_max_xor (rsp_max_xor)
   );

endmodule

`default_nettype wire

FILE: hdl/rmxt_checker.sv
// ----------------------------------------------------------------------------
// rmxt_checker: response channel checks for the range max-xor trie
// Watches the top level's response ports and is bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmxt_checker #(
   parameter int KEY_BITS = rmxt_pkg::DEF_KEY_BITS
) (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input wire [rmxt_pkg::STATUS_W-1:0]  rsp_status,
   input wire [KEY_BITS-1:0]            rsp_max_xor
);
   import rmxt_pkg::*;

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_max_xor))
      else $error("stalled response changed or dropped");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_max_xor == '0)
      else $error("error response carries a nonzero maximum");

   // nothing comes out before a request has passed the queue
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response shortly after reset");

endmodule

bind range_max_xor_persistent_trie rmxt_checker #(
   .KEY_BITS (KEY_BITS)
) u_rmxt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_max_xor (rsp_max_xor)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for range_max_xor_persistent_trie
// Drives append and range max-xor query transactions with random sender gaps
// and receiver stalls. Each accepted request updates a flat prefix-xor
// history kept here, and each query answer is found by scanning the range.
// Every response is checked in order against the answers that are due.
// ----------------------------------------------------------------------------

module tb_top;

   import rmxt_pkg::*;

   localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
   localparam int KEY_BITS    = DEF_KEY_BITS;
   localparam int ENTRY_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int SETTLE_CYCLES = 120;

   localparam logic [KEY_BITS-1:0] KEY_ONES   = {KEY_BITS{1'b1}};
   localparam logic [ENTRY_W-1:0]  INDEX_ONES = {ENTRY_W{1'b1}};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_BITS-1:0] max_xor;
   } answer_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_cmd;
   logic [KEY_BITS-1:0] req_value;
   logic [ENTRY_W-1:0]  req_range_first;
   logic [ENTRY_W-1:0]  req_range_last;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [KEY_BITS-1:0] rsp_max_xor;

   // history of prefix xors, 1-based; entry 1 is the zero entry
   logic [KEY_BITS-1:0] prefix_hist [0:MAX_ENTRIES];
   int unsigned         entry_total;
   logic [KEY_BITS-1:0] running_total;

   answer_type  answers_due [$];
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   range_max_xor_persistent_trie dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_max_xor     (rsp_max_xor)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one accepted request to the history and return its answer.
   function automatic answer_type apply_request(input logic cmd,
                                                input logic [KEY_BITS-1:0] value,
                                                input logic [ENTRY_W-1:0] first,
                                                input logic [ENTRY_W-1:0] last);
      answer_type          ans;
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] cand;
      ans.status  = STATUS_OK;
      ans.max_xor = '0;
      if (cmd == CMD_APPEND) begin
         if (entry_total >= MAX_ENTRIES) begin
            ans.status = STATUS_FULL;
         end else begin
            running_total = running_total ^ value;
            entry_total++;
            prefix_hist[entry_total] = running_total;
         end
      end else if (first == 0 || first > last || last > entry_total) begin
         ans.status = STATUS_RANGE;
      end else begin
         key = running_total ^ value;
         for (int i = first; i <= last; i++) begin
            cand = prefix_hist[i] ^ key;
            if (cand > ans.max_xor) ans.max_xor = cand;
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Hold each transaction until accepted, then record its answer.
   task automatic send_request(input logic cmd, input logic [KEY_BITS-1:0] value,
                               input logic [ENTRY_W-1:0] first,
                               input logic [ENTRY_W-1:0] last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cmd         = cmd;
      req_value       = value;
      req_range_first = first;
      req_range_last  = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answers_due = {answers_due, apply_request(cmd, value, first, last)};
   endtask

   task automatic append_value(input logic [KEY_BITS-1:0] value);
      send_request(CMD_APPEND, value, ENTRY_W'($urandom_range(0, 8191)),
                   ENTRY_W'($urandom_range(0, 8191)));
   endtask

   task automatic query_range(input int unsigned first, input int unsigned last,
                              input logic [KEY_BITS-1:0] x);
      send_request(CMD_QUERY, x, first[ENTRY_W-1:0], last[ENTRY_W-1:0]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_BITS-1:0] pick_key();
      logic [KEY_BITS-1:0] one_hot;
      one_hot = '0;
      one_hot[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return KEY_ONES;
         2: return one_hot;
         3: return ~one_hot;
         default: return KEY_BITS'($urandom());
      endcase
   endfunction

   task automatic test_directed_basics();
      query_range(1, 1, '0);
      query_range(1, 1, KEY_ONES);
      append_value(KEY_ONES);
      append_value('0);
      append_value(24'h5A5A5A);
      append_value(24'h800001);
      query_range(1, entry_total, '0);
      query_range(2, 3, KEY_ONES);
      query_range(entry_total, entry_total, 24'h123456);
      query_range(1, 1, '0);
      query_range(1, entry_total, KEY_ONES);
   endtask

   task automatic test_bad_ranges();
      query_range(0, 1, 24'hABCDEF);
      query_range(0, 0, '0);
      query_range(3, 2, KEY_ONES);
      query_range(1, entry_total + 1, '0);
      query_range(32'(INDEX_ONES), 32'(INDEX_ONES), KEY_ONES);
      query_range(1, 32'(INDEX_ONES), 24'h000001);
   endtask

   task automatic test_random_traffic(input int n_items, input int unsigned gap_pct,
                                      input int unsigned stall_pct);
      int unsigned first;
      int unsigned last;
      int unsigned pick;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            append_value(pick_key());
         end else if (pick < 90) begin
            case ($urandom_range(0, 3))
               0: begin
                  first = $urandom_range(1, entry_total);
                  last  = first;
               end
               1: begin
                  first = 1;
                  last  = entry_total;
               end
               default: begin
                  first = $urandom_range(1, entry_total);
                  last  = $urandom_range(first, entry_total);
               end
            endcase
            query_range(first, last, pick_key());
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  first = 0;
                  last  = $urandom_range(0, 8191);
               end
               1: begin
                  last  = $urandom_range(1, entry_total);
                  first = $urandom_range(last + 1, 8191);
               end
               2: begin
                  first = $urandom_range(1, entry_total);
                  last  = $urandom_range(entry_total + 1, 8191);
               end
               default: begin
                  first = $urandom_range(0, 8191);
                  last  = $urandom_range(0, 8191);
               end
            endcase
            query_range(first, last, pick_key());
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response with none outstanding", 32'(rsp_status), 0);
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status) begin
               report_mismatch("status", 32'(rsp_status), 32'(due.status));
            end
            if (rsp_max_xor !== due.max_xor) begin
               report_mismatch("max_xor", 32'(rsp_max_xor), 32'(due.max_xor));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_APPEND;
      req_value       = '0;
      req_range_first = '0;
      req_range_last  = '0;
      rsp_stall       = 1'b0;
      error_count     = 0;
      cycle_count     = 0;
      send_gap_pct    = 8;
      recv_stall_pct  = 53;
      entry_total     = 1;
      running_total   = '0;
      prefix_hist[1]  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_basics();
      test_bad_ranges();
      test_random_traffic(300, 8, 53);
      test_random_traffic(300, 53, 8);
      test_random_traffic(300, 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
